// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// ===== rtl/prp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package prp_pkg;

  // Raw word size in the record stream.
  localparam int WORD_BYTES = 4;
  localparam int WORD_BITS  = 8 * WORD_BYTES;

  localparam int VALUE_W    = 62;
  localparam int ACCUM_W    = 64;
  localparam int CFG_IDX_W  = 4;

  // Largest term id that fits 32 bits.
  localparam logic [ACCUM_W-1:0] TERM_ID_MAX = 64'h0000_0000_FFFF_FFFF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WITH_POSITIONS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WORDS      = 4'd1;

  // Result kinds.
  localparam logic [2:0] KIND_TERM_ID   = 3'd0;
  localparam logic [2:0] KIND_DOC_COUNT = 3'd1;
  localparam logic [2:0] KIND_DOC_ID    = 3'd2;
  localparam logic [2:0] KIND_FREQ      = 3'd3;
  localparam logic [2:0] KIND_POS_COUNT = 3'd4;
  localparam logic [2:0] KIND_POSITION  = 3'd5;
  localparam logic [2:0] KIND_RUN_END   = 3'd6;
  localparam logic [2:0] KIND_ERROR     = 3'd7;

  // Error codes.
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_TERM_WIDE = 3'd1;
  localparam logic [2:0] ERR_COUNT     = 3'd2;
  localparam logic [2:0] ERR_TRUNC     = 3'd3;
  localparam logic [2:0] ERR_OVERLONG  = 3'd4;

  // Parser phase.
  typedef enum logic [2:0] {
    PH_TERM   = 3'd0,
    PH_DCOUNT = 3'd1,
    PH_DOCS   = 3'd2,
    PH_FREQS  = 3'd3,
    PH_PCOUNT = 3'd4,
    PH_POS    = 3'd5,
    PH_SKIP   = 3'd6,
    PH_ENDED  = 3'd7
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } byte_item_t;

  typedef struct packed {
    logic [2:0]         field_kind;
    logic [VALUE_W-1:0] field_value;
    logic [2:0]         error_code;
    logic               record_last;
  } field_item_t;

endpackage

`default_nettype wire

// ===== rtl/posting_record_parser_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Channel   Handshake               Payload
// -------   ---------------------   --------------------------------------
// byte      byte_valid/byte_ready   byte_item  (data_byte, stream_end)
// field     field_valid/field_ready field_item (kind, value, code, last)
// cfg       cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One byte per clock while byte_ready is high. The result of the byte that
// completes a field is registered into the output register, or into the skid register while the output stalls.
// Synchronous reset clears the parser to "expecting term id" and restores
// with_positions = 1, max_words = 2^62-1.
// A stalled result moves to a one-entry skid register; byte_ready drops
// only while the skid register is full. cfg_ready is always high.

module posting_record_parser_core (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  byte_valid,
  output logic                                 byte_ready,
  input  wire  prp_pkg::byte_item_t            byte_item,
  output logic                                 field_valid,
  input  wire                                  field_ready,
  output prp_pkg::field_item_t                 field_item,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [prp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [prp_pkg::VALUE_W-1:0]          cfg_data
);

  // Configuration
  logic                         with_positions;
  logic [prp_pkg::VALUE_W-1:0]  max_words;

  // Parser state
  prp_pkg::phase_t              phase, phase_next;
  logic [prp_pkg::ACCUM_W-1:0]  varint_accum, varint_accum_next;
  logic [3:0]                   vidx, vidx_next;
  logic [23:0]                  word_accum, word_accum_next;
  logic [1:0]                   widx, widx_next;
  logic [prp_pkg::VALUE_W-1:0]  words_remaining, words_remaining_next;
  logic [prp_pkg::VALUE_W-1:0]  doc_count_saved, doc_count_saved_next;
  logic                         failed, failed_next;

  // Output register and skid
  logic                         skid_valid;
  prp_pkg::field_item_t         skid_item;

  // Decode
  logic                         take;
  logic                         active;
  logic                         in_varint;
  logic [6:0]                   vshift;
  logic [prp_pkg::ACCUM_W-1:0]  vsum;
  logic                         v_cont;
  logic                         v_over;
  logic                         count_over;
  logic                         word_done;
  logic [prp_pkg::WORD_BITS-1:0] word;
  logic [prp_pkg::VALUE_W-1:0]  wr_dec;
  logic                         wr_last;
  logic                         res_valid;
  prp_pkg::field_item_t         res;

  assign cfg_ready  = 1'b1;
  assign byte_ready = !skid_valid;
  assign take       = byte_valid && byte_ready;
  assign active     = !failed && (phase != prp_pkg::PH_ENDED);
  assign in_varint  = (phase == prp_pkg::PH_TERM) || (phase == prp_pkg::PH_DCOUNT) ||
                      (phase == prp_pkg::PH_PCOUNT);

  // Varint: merge the 7-bit group at its slot; bits past bit 63 fall off
  assign vshift     = 7'(vidx) * 7'd7;
  assign vsum       = varint_accum |
                      ({57'd0, byte_item.data_byte[6:0]} << vshift);
  assign v_cont     = byte_item.data_byte[7];
  assign v_over     = v_cont && (vidx >= 4'd9);
  assign count_over = vsum > {2'b00, max_words};

  // Raw words, little endian
  assign word_done  = widx == 2'(prp_pkg::WORD_BYTES - 1);
  assign word       = {byte_item.data_byte, word_accum};
  assign wr_dec     = (words_remaining != '0) ? words_remaining - 1'b1 : '0;
  assign wr_last    = wr_dec == '0;

  // Result for the current byte
  always_comb begin
    res_valid       = 1'b0;
    res.field_kind  = prp_pkg::KIND_ERROR;
    res.field_value = '0;
    res.error_code  = prp_pkg::ERR_NONE;
    res.record_last = 1'b0;
    if (take && active) begin
      if (byte_item.stream_end) begin
        res_valid = 1'b1;
        if (phase == prp_pkg::PH_TERM && vidx == 4'd0) begin
          res.field_kind = prp_pkg::KIND_RUN_END;
        end else begin
          res.error_code = prp_pkg::ERR_TRUNC;
        end
      end else if (in_varint) begin
        if (v_cont) begin
          if (v_over) begin
            res_valid      = 1'b1;
            res.error_code = prp_pkg::ERR_OVERLONG;
          end
        end else begin
          res_valid = 1'b1;
          case (phase)
            prp_pkg::PH_TERM: begin
              if (vsum > prp_pkg::TERM_ID_MAX) begin
                res.error_code = prp_pkg::ERR_TERM_WIDE;
              end else begin
                res.field_kind  = prp_pkg::KIND_TERM_ID;
                res.field_value = vsum[prp_pkg::VALUE_W-1:0];
              end
            end
            prp_pkg::PH_DCOUNT: begin
              if (count_over) begin
                res.error_code = prp_pkg::ERR_COUNT;
              end else begin
                res.field_kind  = prp_pkg::KIND_DOC_COUNT;
                res.field_value = vsum[prp_pkg::VALUE_W-1:0];
              end
            end
            default: begin
              if (count_over) begin
                res.error_code = prp_pkg::ERR_COUNT;
              end else begin
                res.field_kind  = prp_pkg::KIND_POS_COUNT;
                res.field_value = vsum[prp_pkg::VALUE_W-1:0];
                res.record_last = (vsum == '0) || !with_positions;
              end
            end
          endcase
        end
      end else if (word_done) begin
        res.field_value = {{(prp_pkg::VALUE_W - prp_pkg::WORD_BITS){1'b0}}, word};
        case (phase)
          prp_pkg::PH_DOCS: begin
            res_valid      = 1'b1;
            res.field_kind = prp_pkg::KIND_DOC_ID;
          end
          prp_pkg::PH_FREQS: begin
            res_valid      = 1'b1;
            res.field_kind = prp_pkg::KIND_FREQ;
          end
          prp_pkg::PH_POS: begin
            res_valid       = 1'b1;
            res.field_kind  = prp_pkg::KIND_POSITION;
            res.record_last = wr_last;
          end
          default: begin
            res_valid = 1'b0;
          end
        endcase
      end
    end
  end

  // Next parser state
  always_comb begin
    phase_next           = phase;
    varint_accum_next    = varint_accum;
    vidx_next            = vidx;
    word_accum_next      = word_accum;
    widx_next            = widx;
    words_remaining_next = words_remaining;
    doc_count_saved_next = doc_count_saved;
    failed_next          = failed;
    if (take && active) begin
      if (byte_item.stream_end) begin
        if (phase == prp_pkg::PH_TERM && vidx == 4'd0) begin
          phase_next = prp_pkg::PH_ENDED;
        end else begin
          failed_next = 1'b1;
        end
      end else if (in_varint) begin
        if (v_cont) begin
          varint_accum_next = vsum;
          if (v_over) begin
            failed_next = 1'b1;
          end else begin
            vidx_next = vidx + 4'd1;
          end
        end else begin
          varint_accum_next = '0;
          vidx_next         = 4'd0;
          case (phase)
            prp_pkg::PH_TERM: begin
              if (vsum > prp_pkg::TERM_ID_MAX) begin
                failed_next = 1'b1;
              end else begin
                phase_next = prp_pkg::PH_DCOUNT;
              end
            end
            prp_pkg::PH_DCOUNT: begin
              if (count_over) begin
                failed_next = 1'b1;
              end else begin
                doc_count_saved_next = vsum[prp_pkg::VALUE_W-1:0];
                words_remaining_next = vsum[prp_pkg::VALUE_W-1:0];
                phase_next = (vsum == '0) ? prp_pkg::PH_PCOUNT : prp_pkg::PH_DOCS;
              end
            end
            default: begin
              if (count_over) begin
                failed_next = 1'b1;
              end else begin
                words_remaining_next = vsum[prp_pkg::VALUE_W-1:0];
                if (vsum == '0) begin
                  phase_next = prp_pkg::PH_TERM;
                end else if (with_positions) begin
                  phase_next = prp_pkg::PH_POS;
                end else begin
                  phase_next = prp_pkg::PH_SKIP;
                end
              end
            end
          endcase
        end
      end else if (!word_done) begin
        word_accum_next = word_accum | ({16'd0, byte_item.data_byte} << {widx, 3'b000});
        widx_next       = widx + 2'd1;
      end else begin
        word_accum_next      = '0;
        widx_next            = 2'd0;
        words_remaining_next = wr_dec;
        case (phase)
          prp_pkg::PH_DOCS: begin
            if (wr_last) begin
              phase_next           = prp_pkg::PH_FREQS;
              words_remaining_next = doc_count_saved;
            end
          end
          prp_pkg::PH_FREQS: begin
            if (wr_last) phase_next = prp_pkg::PH_PCOUNT;
          end
          default: begin
            // positions, emitted or skipped
            if (wr_last) phase_next = prp_pkg::PH_TERM;
          end
        endcase
      end
    end
  end

  // Parser and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= prp_pkg::PH_TERM;
      varint_accum    <= '0;
      vidx            <= 4'd0;
      word_accum      <= '0;
      widx            <= 2'd0;
      words_remaining <= '0;
      doc_count_saved <= '0;
      failed          <= 1'b0;
      with_positions  <= 1'b1;
      max_words       <= '1;
    end else begin
      phase           <= phase_next;
      varint_accum    <= varint_accum_next;
      vidx            <= vidx_next;
      word_accum      <= word_accum_next;
      widx            <= widx_next;
      words_remaining <= words_remaining_next;
      doc_count_saved <= doc_count_saved_next;
      failed          <= failed_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == prp_pkg::CFG_WITH_POSITIONS) with_positions <= cfg_data[0];
        if (cfg_index == prp_pkg::CFG_MAX_WORDS)      max_words      <= cfg_data;
      end
    end
  end

  // Output register and skid: valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      field_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (field_valid && field_ready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!res_valid) begin
        field_valid <= 1'b0;
      end
    end else if (!field_valid) begin
      field_valid <= res_valid;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Output register and skid: payload
  always_ff @(posedge clk) begin
    if (field_valid && field_ready) begin
      if (skid_valid) begin
        field_item <= skid_item;
      end else if (res_valid) begin
        field_item <= res;
      end
    end else if (!field_valid) begin
      if (res_valid) field_item <= res;
    end else if (res_valid) begin
      skid_item <= res;
    end
  end

  // Checks
  `ASSERT_NEXT(a_failed_sticky, clk, rst, failed, failed)
  `ASSERT_IMPLIES(a_skid_behind_out, clk, rst, skid_valid, field_valid)
  `ASSERT_NEXT(a_stall_fills_skid, clk, rst, field_valid && !field_ready && res_valid, skid_valid)
  `ASSERT_IMPLIES(a_error_clean, clk, rst, field_valid && field_item.field_kind == prp_pkg::KIND_ERROR, field_item.field_value == '0 && !field_item.record_last)

endmodule

`default_nettype wire
